// ----- rtl/slu_pkg.sv -----
// Package with types, codes and helper functions of the string literal unescaper.
package slu_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned LineWidth   = 20;
  localparam int unsigned ColumnWidth = 16;

  localparam logic [CharWidth-1:0] ChrNul   = 8'h00;
  localparam logic [CharWidth-1:0] ChrBs    = 8'h08;
  localparam logic [CharWidth-1:0] ChrTab   = 8'h09;
  localparam logic [CharWidth-1:0] ChrLf    = 8'h0A;
  localparam logic [CharWidth-1:0] ChrVt    = 8'h0B;
  localparam logic [CharWidth-1:0] ChrFf    = 8'h0C;
  localparam logic [CharWidth-1:0] ChrCr    = 8'h0D;
  localparam logic [CharWidth-1:0] ChrDquote = 8'h22;
  localparam logic [CharWidth-1:0] ChrSquote = 8'h27;
  localparam logic [CharWidth-1:0] ChrBslash = 8'h5C;
  localparam logic [CharWidth-1:0] ChrLowerX = 8'h78;
  localparam logic [CharWidth-1:0] ChrZero   = 8'h30;
  localparam logic [CharWidth-1:0] ChrLowerB = 8'h62;
  localparam logic [CharWidth-1:0] ChrLowerT = 8'h74;
  localparam logic [CharWidth-1:0] ChrLowerN = 8'h6E;
  localparam logic [CharWidth-1:0] ChrLowerV = 8'h76;
  localparam logic [CharWidth-1:0] ChrLowerF = 8'h66;
  localparam logic [CharWidth-1:0] ChrLowerR = 8'h72;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX1 = 3'd3,
    MODE_HEX2 = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_END     = 3'd1,
    ST_EOL     = 3'd2,
    ST_HEX     = 3'd3,
    ST_NUL     = 3'd4,
    ST_NOQUOTE = 3'd5
  } status_e;

  typedef struct packed {
    logic [CharWidth-1:0]   char_in;
    logic [LineWidth-1:0]   start_line;
    logic [ColumnWidth-1:0] start_column;
  } in_item_t;

  typedef struct packed {
    logic [CharWidth-1:0]   char_out;
    logic [2:0]             status;
    logic                   last;
    logic [LineWidth-1:0]   error_line;
    logic [ColumnWidth-1:0] error_column;
  } out_item_t;

  // Result of a hex digit lookup: valid flag and the nibble.
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [CharWidth-1:0] c);
    hex_digit_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok    = 1'b1;
      r.value = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic logic [CharWidth-1:0] esc_decode(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] r;
    case (c)
      ChrZero:   r = ChrNul;
      ChrLowerB: r = ChrBs;
      ChrLowerT: r = ChrTab;
      ChrLowerN: r = ChrLf;
      ChrLowerV: r = ChrVt;
      ChrLowerF: r = ChrFf;
      ChrLowerR: r = ChrCr;
      default:   r = c;
    endcase
    return r;
  endfunction

  function automatic logic [ColumnWidth-1:0] sat_inc(input logic [ColumnWidth-1:0] c);
    return (&c) ? c : c + ColumnWidth'(1);
  endfunction

endpackage

// ----- rtl/slu_if.sv -----
// Valid/ready channel interfaces for source bytes and decoded results.
interface slu_in_if;
  logic                              valid;
  logic                              ready;
  logic [slu_pkg::CharWidth-1:0]     char_in;
  logic [slu_pkg::LineWidth-1:0]     start_line;
  logic [slu_pkg::ColumnWidth-1:0]   start_column;

  modport source (output valid, char_in, start_line, start_column, input ready);
  modport sink   (input valid, char_in, start_line, start_column, output ready);
endinterface

interface slu_out_if;
  logic                              valid;
  logic                              ready;
  logic [slu_pkg::CharWidth-1:0]     char_out;
  logic [2:0]                        status;
  logic                              last;
  logic [slu_pkg::LineWidth-1:0]     error_line;
  logic [slu_pkg::ColumnWidth-1:0]   error_column;

  modport source (output valid, char_out, status, last, error_line, error_column,
                  input ready);
  modport sink   (input valid, char_out, status, last, error_line, error_column,
                  output ready);
endinterface

// ----- rtl/string_literal_unescaper.sv -----
// Top level of the string literal unescaper: input register, decoder, result register.
//
//   Channel  Direction  Payload
//   in_i     sink       char_in, start_line, start_column
//   out_o    source     char_out, status, last, error_line, error_column
//
// One source byte per cycle in steady state while the receiver takes results; a
// result passes through the input register and then the result register.
// The decoder state advances when the buffered byte moves on. A result that waits
// in the result register holds the byte in the input register and drops input
// ready in that same cycle, even when the byte would produce no result.
// Bytes that produce no result (opening quote, backslash, the x of a hex escape,
// first hex digit) still advance the decoder. Reset returns the block to the idle
// mode with both registers empty.
module string_literal_unescaper (
  input  logic     clk_i,
  input  logic     rst_ni,
  slu_in_if.sink   in_i,
  slu_out_if.source out_o
);
  import slu_pkg::*;

  logic      in_valid_q, in_valid_d;
  in_item_t  in_data_q;
  logic      step;
  logic      out_free;
  logic      res_valid;
  out_item_t res;

  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || step;
  assign in_valid_d = in_i.ready ? in_i.valid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= '{char_in:      in_i.char_in,
                     start_line:   in_i.start_line,
                     start_column: in_i.start_column};
    end
  end

  slu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slu_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// ----- rtl/slu_decode.sv -----
// Literal state machine: decodes one byte per step and updates mode and position.
module slu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  slu_pkg::in_item_t item_i,
  output logic              res_valid_o,
  output slu_pkg::out_item_t res_o
);
  import slu_pkg::*;

  mode_e                  mode_q, mode_d;
  logic [CharWidth-1:0]   quote_q, quote_d;
  logic [3:0]             hex_q, hex_d;
  logic [LineWidth-1:0]   line_q, line_d;
  logic [ColumnWidth-1:0] col_q, col_d;

  logic [CharWidth-1:0]   c;
  hex_digit_t             hd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      quote_q <= '0;
      hex_q   <= '0;
      line_q  <= '0;
      col_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      hex_q   <= hex_d;
      line_q  <= line_d;
      col_q   <= col_d;
    end
  end

  assign c  = item_i.char_in;
  assign hd = hex_value(c);

  always_comb begin
    mode_d      = mode_q;
    quote_d     = quote_q;
    hex_d       = hex_q;
    line_d      = line_q;
    col_d       = col_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (mode_q)
      MODE_BODY: begin
        if (c == ChrLf || c == ChrCr || c == ChrNul) begin
          mode_d             = MODE_IDLE;
          res_valid_o        = 1'b1;
          res_o.status       = (c == ChrNul) ? ST_NUL : ST_EOL;
          res_o.last         = 1'b1;
          res_o.error_line   = line_q;
          res_o.error_column = col_q;
        end else if (c == quote_q) begin
          mode_d       = MODE_IDLE;
          col_d        = sat_inc(col_q);
          res_valid_o  = 1'b1;
          res_o.status = ST_END;
          res_o.last   = 1'b1;
        end else begin
          col_d = sat_inc(col_q);
          if (c == ChrBslash) begin
            mode_d = MODE_ESC;
          end else begin
            res_valid_o    = 1'b1;
            res_o.char_out = c;
            res_o.status   = ST_BYTE;
          end
        end
      end
      MODE_ESC: begin
        if (c == ChrNul) begin
          mode_d             = MODE_IDLE;
          res_valid_o        = 1'b1;
          res_o.status       = ST_NUL;
          res_o.last         = 1'b1;
          res_o.error_line   = line_q;
          res_o.error_column = col_q;
        end else begin
          col_d = sat_inc(col_q);
          if (c == ChrLowerX) begin
            mode_d = MODE_HEX1;
          end else begin
            mode_d         = MODE_BODY;
            res_valid_o    = 1'b1;
            res_o.char_out = esc_decode(c);
            res_o.status   = ST_BYTE;
          end
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hd.ok) begin
          mode_d             = MODE_IDLE;
          res_valid_o        = 1'b1;
          res_o.status       = ST_HEX;
          res_o.last         = 1'b1;
          res_o.error_line   = line_q;
          res_o.error_column = col_q;
        end else begin
          col_d = sat_inc(col_q);
          if (mode_q == MODE_HEX1) begin
            hex_d  = hd.value;
            mode_d = MODE_HEX2;
          end else begin
            mode_d         = MODE_BODY;
            res_valid_o    = 1'b1;
            res_o.char_out = {hex_q, hd.value};
            res_o.status   = ST_BYTE;
          end
        end
      end
      default: begin
        if (c == ChrDquote || c == ChrSquote) begin
          quote_d = c;
          line_d  = item_i.start_line;
          col_d   = sat_inc(item_i.start_column);
          hex_d   = '0;
          mode_d  = MODE_BODY;
        end else begin
          mode_d             = MODE_IDLE;
          res_valid_o        = 1'b1;
          res_o.status       = ST_NOQUOTE;
          res_o.last         = 1'b1;
          res_o.error_line   = item_i.start_line;
          res_o.error_column = item_i.start_column;
        end
      end
    endcase
  end

endmodule

// ----- rtl/slu_out_reg.sv -----
// Result register that drives the output channel.
module slu_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  slu_pkg::out_item_t res_i,
  output logic               free_o,
  slu_out_if.source          out_o
);
  import slu_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  // The register can take a new result when it is empty or its transfer completes now.
  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.char_out     = data_q.char_out;
  assign out_o.status       = data_q.status;
  assign out_o.last         = data_q.last;
  assign out_o.error_line   = data_q.error_line;
  assign out_o.error_column = data_q.error_column;

endmodule

// ----- rtl/slu_checker.sv -----
// Port-level checks for the string literal unescaper, bound to the top level.
module slu_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [slu_pkg::CharWidth-1:0]    char_out_i,
  input logic [2:0]                       status_i,
  input logic                             last_i,
  input logic [slu_pkg::LineWidth-1:0]    error_line_i,
  input logic [slu_pkg::ColumnWidth-1:0]  error_column_i
);
  import slu_pkg::*;

  // A pending result stays offered until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output result dropped before transfer");

  // Decoded bytes never finish a literal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_BYTE |-> !last_i)
    else $error("decoded byte marked as last");

  // Every end or error result finishes the literal and carries no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_BYTE |-> last_i && char_out_i == '0)
    else $error("end or error result malformed");

  // A normal end reports no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_END |-> error_line_i == '0 && error_column_i == '0)
    else $error("end result carries a position");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_NOQUOTE)
    else $error("undefined status code");

endmodule

bind string_literal_unescaper slu_checker u_slu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .char_out_i     (out_o.char_out),
  .status_i       (out_o.status),
  .last_i         (out_o.last),
  .error_line_i   (out_o.error_line),
  .error_column_i (out_o.error_column)
);

// ----- verif/tb_string_literal_unescaper.sv -----
// Self-checking testbench for the string literal unescaper.
`timescale 1ns / 100ps

module tb_string_literal_unescaper;
  import slu_pkg::*;

  localparam int unsigned TotalBytes = 1150;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles = 8;

  // Predicts the decoder from the accepted source bytes and checks each result
  // against the oldest prediction still waiting.
  class decoded_byte_board;
    mode_e                  mode;
    logic [CharWidth-1:0]   quote;
    logic [3:0]             hex_high;
    logic [LineWidth-1:0]   line_no;
    logic [ColumnWidth-1:0] column_no;
    out_item_t              expected_results[$];
    int unsigned            errors;
    int unsigned            bytes_in;
    int unsigned            checked;
    int unsigned            status_seen[6];

    function new();
      mode      = MODE_IDLE;
      quote     = '0;
      hex_high  = '0;
      line_no   = '0;
      column_no = '0;
      errors    = 0;
      bytes_in  = 0;
      checked   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [ColumnWidth-1:0] bump(input logic [ColumnWidth-1:0] c);
      if (c == '1) return c;
      return c + 1'b1;
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function logic [4:0] nibble(input logic [CharWidth-1:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
      return 5'd0;
    endfunction

    function logic [CharWidth-1:0] unescape(input logic [CharWidth-1:0] c);
      case (c)
        ChrZero:   return ChrNul;
        ChrLowerB: return ChrBs;
        ChrLowerT: return ChrTab;
        ChrLowerN: return ChrLf;
        ChrLowerV: return ChrVt;
        ChrLowerF: return ChrFf;
        ChrLowerR: return ChrCr;
        default:   return c;
      endcase
    endfunction

    function out_item_t abort_literal(input status_e st);
      out_item_t r;
      r = '0;
      mode = MODE_IDLE;
      r.status       = st;
      r.last         = 1'b1;
      r.error_line   = line_no;
      r.error_column = column_no;
      return r;
    endfunction

    function void absorb_source_byte(input in_item_t it);
      logic [CharWidth-1:0] c;
      logic [4:0]           d;
      out_item_t            r;
      logic                 have;
      c = it.char_in;
      r = '0;
      have = 1'b0;
      bytes_in++;
      case (mode)
        MODE_BODY: begin
          if (c == ChrLf || c == ChrCr) begin
            r = abort_literal(ST_EOL);
            have = 1'b1;
          end else if (c == ChrNul) begin
            r = abort_literal(ST_NUL);
            have = 1'b1;
          end else if (c == quote) begin
            mode = MODE_IDLE;
            column_no = bump(column_no);
            r.status = ST_END;
            r.last = 1'b1;
            have = 1'b1;
          end else begin
            column_no = bump(column_no);
            if (c == ChrBslash) begin
              mode = MODE_ESC;
            end else begin
              r.char_out = c;
              have = 1'b1;
            end
          end
        end
        MODE_ESC: begin
          if (c == ChrNul) begin
            r = abort_literal(ST_NUL);
            have = 1'b1;
          end else begin
            column_no = bump(column_no);
            if (c == ChrLowerX) begin
              mode = MODE_HEX1;
            end else begin
              mode = MODE_BODY;
              r.char_out = unescape(c);
              have = 1'b1;
            end
          end
        end
        MODE_HEX1: begin
          d = nibble(c);
          if (!d[4]) begin
            r = abort_literal(ST_HEX);
            have = 1'b1;
          end else begin
            hex_high = d[3:0];
            column_no = bump(column_no);
            mode = MODE_HEX2;
          end
        end
        MODE_HEX2: begin
          d = nibble(c);
          if (!d[4]) begin
            r = abort_literal(ST_HEX);
            have = 1'b1;
          end else begin
            column_no = bump(column_no);
            mode = MODE_BODY;
            r.char_out = {hex_high, d[3:0]};
            have = 1'b1;
          end
        end
        default: begin
          if (c == ChrDquote || c == ChrSquote) begin
            quote     = c;
            line_no   = it.start_line;
            column_no = bump(it.start_column);
            hex_high  = '0;
            mode      = MODE_BODY;
          end else begin
            mode = MODE_IDLE;
            r.status       = ST_NOQUOTE;
            r.last         = 1'b1;
            r.error_line   = it.start_line;
            r.error_column = it.start_column;
            have = 1'b1;
          end
        end
      endcase
      if (have) expected_results.push_back(r);
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_decoded(input out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d char_out 0x%0h", got.status, got.char_out);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.status < 6) status_seen[got.status]++;
      compare_field("char_out", want.char_out, got.char_out);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
      compare_field("error_line", want.error_line, got.error_line);
      compare_field("error_column", want.error_column, got.error_column);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned burst_left;

  slu_in_if  in_ch ();
  slu_out_if out_ch ();

  decoded_byte_board board = new();

  string_literal_unescaper i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Both channels are sampled here, with the values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_decoded({out_ch.char_out, out_ch.status, out_ch.last,
                             out_ch.error_line, out_ch.error_column});
      end
      if (in_ch.valid && in_ch.ready) begin
        board.absorb_source_byte({in_ch.char_in, in_ch.start_line, in_ch.start_column});
      end
    end
  end

  // Receiver: random stall styles in stretches, plus one long hold-off once
  // traffic is flowing, so the block fills up and pushes back on its input.
  int unsigned hold_left;
  logic        hold_done;
  int unsigned style_left;
  int unsigned stall_style;

  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    style_left   = 0;
    stall_style  = 0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && board.checked >= 150) begin
      hold_done = 1'b1;
      hold_left = LongHoldCycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(10, 150);
      end
      style_left--;
      case (stall_style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 1) != 0);
        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic logic [LineWidth-1:0] pick_line();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return LineWidth'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  function automatic logic [ColumnWidth-1:0] pick_column();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return ColumnWidth'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return ColumnWidth'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Offers one byte and returns once it has been transferred. Between bursts
  // valid drops for a random gap.
  task automatic send_byte(input logic [CharWidth-1:0] c,
                           input logic [LineWidth-1:0] ln,
                           input logic [ColumnWidth-1:0] col);
    in_ch.valid        <= 1'b1;
    in_ch.char_in      <= c;
    in_ch.start_line   <= ln;
    in_ch.start_column <= col;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Inside a literal the start fields are ignored, so they carry noise.
  task automatic send_body(input logic [CharWidth-1:0] c);
    send_byte(c, pick_line(), pick_column());
  endtask

  function automatic logic [CharWidth-1:0] plain_byte(input logic [CharWidth-1:0] q);
    logic [CharWidth-1:0] b;
    do b = CharWidth'($urandom_range(1, 255));
    while (b == ChrLf || b == ChrCr || b == q || b == ChrBslash);
    return b;
  endfunction

  function automatic logic [CharWidth-1:0] escape_letter();
    logic [CharWidth-1:0] b;
    case ($urandom_range(0, 13))
      0:  return ChrZero;
      1:  return ChrLowerB;
      2:  return ChrLowerT;
      3:  return ChrLowerN;
      4:  return ChrLowerV;
      5:  return ChrLowerF;
      6:  return ChrLowerR;
      7:  return ChrDquote;
      8:  return ChrSquote;
      9:  return ChrBslash;
      10: return ChrLf;
      11: return ChrCr;
      default: begin
        do b = CharWidth'($urandom_range(1, 255)); while (b == ChrLowerX);
        return b;
      end
    endcase
  endfunction

  function automatic logic [CharWidth-1:0] hex_char();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return CharWidth'("0" + r);
    if (r < 16) return CharWidth'("a" + r - 10);
    return CharWidth'("A" + r - 16);
  endfunction

  function automatic logic [CharWidth-1:0] non_hex_char();
    logic [CharWidth-1:0] b;
    do b = CharWidth'($urandom_range(0, 255));
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
    return b;
  endfunction

  // Ends the open literal with one of the error conditions.
  task automatic send_broken_tail();
    case ($urandom_range(0, 5))
      0: send_body(ChrLf);
      1: send_body(ChrCr);
      2: send_body(ChrNul);
      3: begin
        send_body(ChrBslash);
        send_body(ChrNul);
      end
      4: begin
        send_body(ChrBslash);
        send_body(ChrLowerX);
        send_body(non_hex_char());
      end
      default: begin
        send_body(ChrBslash);
        send_body(ChrLowerX);
        send_body(hex_char());
        send_body(non_hex_char());
      end
    endcase
  endtask

  task automatic send_literal();
    logic [CharWidth-1:0] q;
    int unsigned          n;
    int unsigned          kind;
    int unsigned          i;
    q = ($urandom_range(0, 1) != 0) ? ChrDquote : ChrSquote;
    send_byte(q, pick_line(), pick_column());
    n = $urandom_range(0, 10);
    for (i = 0; i < n; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        send_body(plain_byte(q));
      end else if (kind < 16) begin
        send_body(ChrBslash);
        send_body(escape_letter());
      end else begin
        send_body(ChrBslash);
        send_body(ChrLowerX);
        send_body(hex_char());
        send_body(hex_char());
      end
    end
    if ($urandom_range(0, 7) == 0) send_broken_tail();
    else send_body(q);
  endtask

  initial begin
    logic [CharWidth-1:0] opener;
    rst_n              = 1'b0;
    cycle_count        = 0;
    bytes_sent         = 0;
    burst_left         = 0;
    in_ch.valid        = 1'b0;
    in_ch.char_in      = '0;
    in_ch.start_line   = '0;
    in_ch.start_column = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening byte that is not a quote, with both start fields at their maximum.
    send_byte(ChrNul, '1, '1);
    // Single-quoted literal starting just below the column limit, so the column
    // saturates; carries a high byte, the other quote kind, \0 and a hex escape.
    send_byte(ChrSquote, '0, 16'hFFFE);
    send_body(8'hFF);
    send_body(ChrDquote);
    send_body(ChrBslash);
    send_body(ChrZero);
    send_body(ChrBslash);
    send_body(ChrLowerX);
    send_body("A");
    send_body("f");
    send_body(ChrSquote);
    // Escaped newline and LF pass through, then a raw CR ends with an error.
    send_byte(ChrDquote, 20'h12345, 16'd7);
    send_body(ChrBslash);
    send_body(ChrLowerN);
    send_body(ChrBslash);
    send_body(ChrLf);
    send_body(ChrCr);
    // NUL right after a backslash.
    send_byte(ChrDquote, 20'h00001, 16'd0);
    send_body(ChrBslash);
    send_body(ChrNul);
    // A byte that is not a hex digit where the first digit is due.
    send_byte(ChrSquote, 20'hFFFFF, 16'hFFFF);
    send_body(ChrBslash);
    send_body(ChrLowerX);
    send_body("G");

    while (bytes_sent < TotalBytes) begin
      if ($urandom_range(0, 15) == 0) begin
        do opener = CharWidth'($urandom_range(0, 255));
        while (opener == ChrDquote || opener == ChrSquote);
        send_byte(opener, pick_line(), pick_column());
      end else begin
        send_literal();
      end
    end
    in_ch.valid <= 1'b0;

    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d source bytes; checked %0d results (%0d bytes, %0d ends).",
             board.bytes_in, board.checked, board.status_seen[ST_BYTE],
             board.status_seen[ST_END]);
    $display("Error results: %0d line end, %0d hex, %0d nul, %0d no quote.",
             board.status_seen[ST_EOL], board.status_seen[ST_HEX],
             board.status_seen[ST_NUL], board.status_seen[ST_NOQUOTE]);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- string_literal_unescaper.f -----
rtl/slu_pkg.sv
rtl/slu_if.sv
rtl/slu_decode.sv
rtl/slu_out_reg.sv
rtl/string_literal_unescaper.sv
rtl/slu_checker.sv
verif/tb_string_literal_unescaper.sv
